// File: rtl/core/kps_pkg.sv
// Shared types and constants for the matrix keypad scanner.
// Used by the configuration, scan core and top-level modules; depends on nothing.
package kps_pkg;

  localparam int LEVEL_WIDTH    = 4;
  localparam int CODE_WIDTH     = 8;
  localparam int COUNT_WIDTH    = 16;
  localparam int MAP_WIDTH      = 64;
  localparam int KEY_CELLS      = 16;
  localparam int CFG_IDX_WIDTH  = 2;

  localparam logic [COUNT_WIDTH-1:0] DEBOUNCE_RESET = 16'd100;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_DEBOUNCE_TICKS = 2'd0,
    CFG_MAP_UPPER      = 2'd1,
    CFG_MAP_LOWER      = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_SCAN     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_RELEASE  = 2'd2,
    PH_RESTART  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] debounce_ticks;
    logic [MAP_WIDTH-1:0]   map_lower;
    logic [MAP_WIDTH-1:0]   map_upper;
  } key_cfg_t;

  typedef struct packed {
    logic [LEVEL_WIDTH-1:0] row_drive;
    logic                   key_valid;
    logic [CODE_WIDTH-1:0]  key_code;
    logic                   pass_empty;
  } scan_result_t;

endpackage

// File: rtl/core/kps_cfg.sv
// Configuration register file of the keypad scanner.
// Depends on kps_pkg.
module kps_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [kps_pkg::CFG_IDX_WIDTH-1:0] wr_index,
  input  logic [kps_pkg::MAP_WIDTH-1:0]     wr_data,
  output kps_pkg::key_cfg_t                 cfg
);
  import kps_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= DEBOUNCE_RESET;
      cfg.map_upper      <= '0;
      cfg.map_lower      <= '0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_DEBOUNCE_TICKS: cfg.debounce_ticks <= wr_data[COUNT_WIDTH-1:0];
        CFG_MAP_UPPER:      cfg.map_upper      <= wr_data;
        CFG_MAP_LOWER:      cfg.map_lower      <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/kps_core.sv
// Scan state machine and result logic of the keypad scanner.
// Depends on kps_pkg; fed by kps_cfg and the input stage of the top level.
module kps_core #(
  parameter int ROW_COUNT    = 4,
  parameter int COLUMN_COUNT = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic [kps_pkg::LEVEL_WIDTH-1:0] levels,
  input  kps_pkg::key_cfg_t               cfg,
  output kps_pkg::scan_result_t           result
);
  import kps_pkg::*;

  localparam int RW    = $clog2(ROW_COUNT);
  localparam int CW    = $clog2(COLUMN_COUNT);
  localparam int CELLW = RW + CW + 2;

  phase_t                 phase, phase_next;
  logic [RW-1:0]          row_index, row_index_next;
  logic [CW-1:0]          column_index, column_index_next;
  logic [COUNT_WIDTH-1:0] debounce_count, debounce_count_next;
  logic                   pass_found_key, pass_found_key_next;

  logic [COLUMN_COUNT-1:0] pressed;
  logic [CW:0]             search_from;
  logic                    hit;
  logic [CW-1:0]           hit_col;
  logic                    cur_pressed;
  logic                    row_last;
  logic                    do_search;
  logic                    release_seen;
  logic [CELLW-1:0]        key_slot;
  logic [CODE_WIDTH-1:0]   map_bytes [KEY_CELLS];

  always_comb begin
    for (int c = 0; c < COLUMN_COUNT; c++) begin
      pressed[c] = (c < LEVEL_WIDTH) ? !levels[c % LEVEL_WIDTH] : 1'b0;
    end
  end

  assign search_from = (phase == PH_DEBOUNCE) ? ({1'b0, column_index} + (CW + 1)'(1))
                                              : '0;

  always_comb begin
    hit     = 1'b0;
    hit_col = '0;
    for (int c = 0; c < COLUMN_COUNT; c++) begin
      if (!hit && pressed[c] && ((CW + 1)'(c) >= search_from)) begin
        hit     = 1'b1;
        hit_col = CW'(c);
      end
    end
  end

  assign cur_pressed  = pressed[column_index];
  assign row_last     = (row_index == RW'(ROW_COUNT - 1));
  assign do_search    = (phase == PH_SCAN) ||
                        ((phase == PH_DEBOUNCE) && (debounce_count == '0) && !cur_pressed);
  assign release_seen = (phase == PH_RELEASE) && !cur_pressed;

  always_comb begin
    phase_next          = phase;
    row_index_next      = row_index;
    column_index_next   = column_index;
    debounce_count_next = debounce_count;
    pass_found_key_next = pass_found_key;
    unique case (phase)
      PH_SCAN: ;
      PH_DEBOUNCE: begin
        if (debounce_count != '0) begin
          debounce_count_next = debounce_count - COUNT_WIDTH'(1);
        end else if (cur_pressed) begin
          phase_next          = PH_RELEASE;
          pass_found_key_next = 1'b1;
        end
      end
      PH_RELEASE: begin
        if (!cur_pressed) begin
          phase_next          = PH_RESTART;
          row_index_next      = '0;
          column_index_next   = '0;
          pass_found_key_next = 1'b0;
        end
      end
      PH_RESTART: begin
        phase_next          = PH_SCAN;
        row_index_next      = '0;
        column_index_next   = '0;
        pass_found_key_next = 1'b0;
      end
    endcase
    if (do_search) begin
      if (hit) begin
        phase_next          = PH_DEBOUNCE;
        column_index_next   = hit_col;
        debounce_count_next = cfg.debounce_ticks;
      end else begin
        phase_next        = PH_SCAN;
        column_index_next = '0;
        if (row_last) begin
          row_index_next      = '0;
          pass_found_key_next = 1'b0;
        end else begin
          row_index_next = row_index + RW'(1);
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < KEY_CELLS; k++) begin
      map_bytes[k] = (k < 8) ? cfg.map_upper[(k % 8) * CODE_WIDTH +: CODE_WIDTH]
                             : cfg.map_lower[(k % 8) * CODE_WIDTH +: CODE_WIDTH];
    end
  end

  assign key_slot = CELLW'(row_index) * CELLW'(COLUMN_COUNT) + CELLW'(column_index);

  always_comb begin
    result.key_valid  = release_seen;
    result.key_code   = '0;
    result.pass_empty = do_search && !hit && row_last && !pass_found_key;
    if (release_seen && (key_slot < CELLW'(KEY_CELLS))) begin
      result.key_code = map_bytes[key_slot[3:0]];
    end
    for (int b = 0; b < LEVEL_WIDTH; b++) begin
      result.row_drive[b] = release_seen ||
                            !((b < ROW_COUNT) && (row_index_next == RW'(b)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SCAN;
      row_index      <= '0;
      column_index   <= '0;
      debounce_count <= '0;
      pass_found_key <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      row_index      <= row_index_next;
      column_index   <= column_index_next;
      debounce_count <= debounce_count_next;
      pass_found_key <= pass_found_key_next;
    end
  end

endmodule

// File: rtl/core/matrix_keypad_scanner.sv
// Top level of the debounced matrix keypad scanner.
// Instantiates kps_cfg and kps_core; depends on kps_pkg.
//
//   channel   direction  width  holds
//   s_axis    in         8      one tick of column samples
//   m_axis    out        16+1   row drive, key code, empty-pass flag; key_valid in tuser
//   cfg       in         2+64   register index and write data
//
// One item is taken every cycle while the output is not stalled; each accepted item
// passes from the input register through the scan logic into the result register.
// Reset restores the register defaults and starts a pass at row 0.
// A stalled result holds in the result register while the input register still fills.
module matrix_keypad_scanner #(
  parameter int ROW_COUNT    = 4,
  parameter int COLUMN_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] column_levels, [7:4] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [3:0] row_drive, [11:4] key_code, [12] pass_empty, [15:13] zero
  output logic        m_tuser,   // [0] key_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import kps_pkg::*;

  key_cfg_t               cfg;
  scan_result_t           result;
  logic                   in_valid;
  logic [LEVEL_WIDTH-1:0] in_levels;
  logic                   fire;

  assign cfg_ready = 1'b1;
  assign fire      = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || fire;

  kps_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  kps_core #(
    .ROW_COUNT    (ROW_COUNT),
    .COLUMN_COUNT (COLUMN_COUNT)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (fire),
    .levels (in_levels),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_levels <= s_tdata[LEVEL_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {3'b000, result.pass_empty, result.key_code, result.row_drive};
      m_tuser <= result.key_valid;
    end
  end

endmodule

// File: rtl/core/kps_checker.sv
// Port-level checks for the matrix keypad scanner, bound to its top level.
// Depends only on the top-level ports.
module kps_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);

  a_report_releases_rows: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[3:0] == 4'hF))
    else $error("key report without all rows released");

  a_report_not_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> !m_tdata[12])
    else $error("key report flagged as empty pass");

  a_code_zero_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[11:4] == 8'h00))
    else $error("nonzero key code without a report");

  a_one_row_driven: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($countones(~m_tdata[3:0]) <= 1))
    else $error("more than one row driven");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind matrix_keypad_scanner kps_checker u_kps_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
